// ----- rtl/swm_pkg.sv -----
`timescale 1ns / 1ps

package swm_pkg;

    // Default configuration of the block.
    localparam int WINDOW_MAX_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 32;

    // Width of the window size register.
    localparam int CFG_W = 7;

    // Sequencer states of the deque engine.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BACK_RD,
        ST_BACK_CMP,
        ST_FRONT_RD,
        ST_FRONT_CMP,
        ST_PUSH,
        ST_EMIT
    } swm_state_t;

endpackage

// ----- rtl/swm_cmp_unit.sv -----
`timescale 1ns / 1ps

module swm_cmp_unit #(
    parameter int CMP_W = 32
) (
    input  logic [CMP_W-1:0] a,
    input  logic [CMP_W-1:0] b,
    output logic             a_le_b
);

    // The one comparator of the block, shared by the tail and the front checks.
    assign a_le_b = (a <= b);

endmodule

// ----- rtl/swm_deque_ram.sv -----
`timescale 1ns / 1ps

module swm_deque_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 39
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/swm_core.sv -----
`timescale 1ns / 1ps

module swm_core #(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [SAMPLE_BITS-1:0]              in_sample,
    input  logic                                in_first,
    input  logic                                in_last,
    input  logic [$clog2(WINDOW_MAX+1)-1:0]     k,
    output logic                                res_valid,
    input  logic                                res_ready,
    output logic [SAMPLE_BITS-1:0]              res_value,
    output logic                                res_final
);

    import swm_pkg::*;

    localparam int IDX_W  = $clog2(WINDOW_MAX);
    localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
    localparam int POS_W  = $clog2(2 * WINDOW_MAX);
    localparam int CMP_W  = (SAMPLE_BITS > POS_W) ? SAMPLE_BITS : POS_W;
    localparam int WORD_W = SAMPLE_BITS + POS_W;

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WINDOW_MAX);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
    localparam logic [IDX_W:0]   SLOT_MOD = (IDX_W + 1)'(WINDOW_MAX);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW_MAX - 1);
    localparam logic [POS_W:0]   POS_MOD  = (POS_W + 1)'(2 * WINDOW_MAX);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(2 * WINDOW_MAX - 1);

    // Slot that lies off entries behind the head, wrapping round the ring.
    function automatic logic [IDX_W-1:0] slot_add(input logic [IDX_W-1:0] head,
                                                  input logic [CNT_W-1:0] off);
        logic [IDX_W:0] sum;
        sum = (IDX_W + 1)'(head) + (IDX_W + 1)'(off);
        if (sum >= SLOT_MOD)
        begin
            sum = sum - SLOT_MOD;
        end
        return sum[IDX_W-1:0];
    endfunction

    // Flipping the sign bit makes an unsigned compare follow signed order.
    function automatic logic [SAMPLE_BITS-1:0] order_key(input logic [SAMPLE_BITS-1:0] v);
        return {~v[SAMPLE_BITS-1], v[SAMPLE_BITS-2:0]};
    endfunction

    swm_state_t state_reg, state_next;

    logic [IDX_W-1:0]       head_reg, head_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [CNT_W-1:0]       filled_reg, filled_next;
    logic [SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic                   last_reg, last_next;
    logic [CNT_W-1:0]       k_reg, k_next;
    logic [SAMPLE_BITS-1:0] front_reg, front_next;

    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [WORD_W-1:0]      ram_wdata;
    logic [IDX_W-1:0]       ram_raddr;
    logic [WORD_W-1:0]      ram_rdata;

    logic [SAMPLE_BITS-1:0] cand_value;
    logic [POS_W-1:0]       cand_pos;
    logic [POS_W:0]         pos_diff;
    logic [POS_W:0]         age_wide;
    logic [POS_W-1:0]       age;
    logic [CNT_W-1:0]       count_dec;
    logic [CMP_W-1:0]       cmp_a;
    logic [CMP_W-1:0]       cmp_b;
    logic                   cmp_le;
    logic                   emit;

    swm_deque_ram #(
        .DEPTH (WINDOW_MAX),
        .WIDTH (WORD_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    swm_cmp_unit #(
        .CMP_W (CMP_W)
    ) u_cmp (
        .a      (cmp_a),
        .b      (cmp_b),
        .a_le_b (cmp_le)
    );

    assign cand_value = ram_rdata[SAMPLE_BITS-1:0];
    assign cand_pos   = ram_rdata[WORD_W-1:SAMPLE_BITS];
    assign count_dec  = count_reg - CNT_ONE;

    // Age of the front candidate, positions counting modulo twice the depth.
    assign pos_diff = {1'b0, pos_reg} - {1'b0, cand_pos};
    assign age_wide = pos_diff[POS_W] ? (pos_diff + POS_MOD) : pos_diff;
    assign age      = age_wide[POS_W-1:0];

    assign emit = (filled_reg >= k_reg) || last_reg;

    always_comb
    begin
        case (state_reg)
            ST_BACK_CMP:
            begin
                cmp_a = CMP_W'(order_key(cand_value));
                cmp_b = CMP_W'(order_key(sample_reg));
            end
            ST_FRONT_CMP:
            begin
                // The front has left the window when k is not above its age.
                cmp_a = CMP_W'(k_reg);
                cmp_b = CMP_W'(age);
            end
            default:
            begin
                cmp_a = '0;
                cmp_b = '0;
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_first || (count_reg == '0))
                    begin
                        state_next = ST_PUSH;
                    end
                    else
                    begin
                        state_next = ST_BACK_RD;
                    end
                end
            end
            ST_BACK_RD:
            begin
                state_next = ST_BACK_CMP;
            end
            ST_BACK_CMP:
            begin
                if (!cmp_le)
                begin
                    state_next = ST_FRONT_RD;
                end
                else if (count_reg == CNT_ONE)
                begin
                    state_next = ST_PUSH;
                end
                else
                begin
                    state_next = ST_BACK_RD;
                end
            end
            ST_FRONT_RD:
            begin
                state_next = ST_FRONT_CMP;
            end
            ST_FRONT_CMP:
            begin
                if (cmp_le && (count_reg != CNT_ONE))
                begin
                    state_next = ST_FRONT_RD;
                end
                else
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!emit || res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        ram_we    = (state_reg == ST_PUSH) && (count_reg != CNT_FULL);
        ram_waddr = slot_add(head_reg, count_reg);
        ram_wdata = {pos_reg, sample_reg};
        ram_raddr = (state_reg == ST_BACK_RD) ? slot_add(head_reg, count_dec) : head_reg;
        res_valid = (state_reg == ST_EMIT) && emit;
        res_value = front_reg;
        res_final = last_reg;
    end

    // Deque bookkeeping.
    always_comb
    begin
        head_next   = head_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        filled_next = filled_reg;
        sample_next = sample_reg;
        last_next   = last_reg;
        k_next      = k_reg;
        front_next  = front_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    sample_next = in_sample;
                    last_next   = in_last;
                    k_next      = k;
                    if (in_first)
                    begin
                        head_next   = '0;
                        count_next  = '0;
                        pos_next    = '0;
                        filled_next = '0;
                    end
                end
            end
            ST_BACK_CMP:
            begin
                if (cmp_le)
                begin
                    count_next = count_dec;
                end
            end
            ST_FRONT_CMP:
            begin
                if (cmp_le)
                begin
                    count_next = count_dec;
                    head_next  = (head_reg == IDX_LAST) ? '0 : head_reg + IDX_W'(1);
                end
                else
                begin
                    front_next = cand_value;
                end
            end
            ST_PUSH:
            begin
                if (count_reg != CNT_FULL)
                begin
                    count_next = count_reg + CNT_ONE;
                end
                // An empty deque means the new sample is itself the maximum.
                if (count_reg == '0)
                begin
                    front_next = sample_reg;
                end
                pos_next = (pos_reg == POS_LAST) ? '0 : pos_reg + POS_W'(1);
                if (filled_reg != CNT_FULL)
                begin
                    filled_next = filled_reg + CNT_ONE;
                end
            end
            ST_EMIT:
            begin
                if (last_reg && res_ready)
                begin
                    head_next   = '0;
                    count_next  = '0;
                    pos_next    = '0;
                    filled_next = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            head_reg   <= '0;
            count_reg  <= '0;
            pos_reg    <= '0;
            filled_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            count_reg  <= count_next;
            pos_reg    <= pos_next;
            filled_reg <= filled_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        last_reg   <= last_next;
        k_reg      <= k_next;
        front_reg  <= front_next;
    end

endmodule

// ----- rtl/sliding_window_maximum.sv -----
`timescale 1ns / 1ps

// Sliding window maximum over signed samples, grouped into sequences by a first
// mark (tuser) and a last mark (tlast). From the k-th sample of a sequence on,
// each sample yields the maximum of the last k samples; a sequence that ends
// before k samples still yields one result, the maximum of what it held, and
// the result of a last-marked sample carries tlast. k is the window_size
// register (0 acts as 1, values above WINDOW_MAX act as WINDOW_MAX), and a new
// value should be written only while no item is in flight. Candidates are kept
// as a monotonic deque in a single-port-read RAM, and one shared comparator
// walks it. An item passes from idle through the deque entries examined at
// the tail and then at the front (each examined entry costs a RAM read and a
// compare; with an empty deque none is examined) to a push and an emit step,
// and each entry is popped at most once over its life. The result sits in an
// output register, so the next item is taken while it waits to be read.

module sliding_window_maximum #(
    parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // Configuration: window_size.
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [swm_pkg::CFG_W-1:0]              cfg_data,
    // Input items.
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_axis_tdata,  // sample, zero pad
    input  logic                                   s_axis_tuser,  // first
    input  logic                                   s_axis_tlast,  // last
    // Result items.
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] m_axis_tdata,  // window_max, zero pad
    output logic                                   m_axis_tlast   // final_res
);

    import swm_pkg::*;

    localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int CNT_W   = $clog2(WINDOW_MAX + 1);
    localparam int KW      = (CFG_W > CNT_W) ? CFG_W : CNT_W;

    logic [CFG_W-1:0]       window_size_reg;
    logic [KW-1:0]          ws_ext;
    logic [CNT_W-1:0]       k_eff;

    logic                   res_valid;
    logic                   res_ready;
    logic [SAMPLE_BITS-1:0] res_value;
    logic                   res_final;

    logic                   out_valid_reg;
    logic [SAMPLE_BITS-1:0] out_value_reg;
    logic                   out_last_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= CFG_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            window_size_reg <= cfg_data;
        end
    end

    // Bring the programmed size into the range the deque supports.
    assign ws_ext = KW'(window_size_reg);

    always_comb
    begin
        if (ws_ext == '0)
        begin
            k_eff = CNT_W'(1);
        end
        else if (ws_ext > KW'(WINDOW_MAX))
        begin
            k_eff = CNT_W'(WINDOW_MAX);
        end
        else
        begin
            k_eff = ws_ext[CNT_W-1:0];
        end
    end

    swm_core #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_sample (s_axis_tdata[SAMPLE_BITS-1:0]),
        .in_first  (s_axis_tuser),
        .in_last   (s_axis_tlast),
        .k         (k_eff),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_value (res_value),
        .res_final (res_final)
    );

    // Output register: a new result may enter as the old one leaves.
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_value_reg <= res_value;
            out_last_reg  <= res_final;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = TDATA_W'(out_value_reg);
    assign m_axis_tlast  = out_last_reg;

    // The sequencer never offers a result while it is waiting for an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !s_axis_tready)
        else $error("result offered while idle");

    // An accepted item keeps the input closed on the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input reopened straight after an item");

    // A result handed over lands in the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_ready) |=> m_axis_tvalid)
        else $error("result lost between core and output register");

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    import swm_pkg::*;

    localparam int WIN_MAX    = WINDOW_MAX_DEF;
    localparam int SMP_W      = SAMPLE_BITS_DEF;
    localparam int DATA_W     = ((SMP_W + 7) / 8) * 8;
    localparam int SETTLE_CYC = 300;
    localparam int STALL_LIM  = 4000;
    localparam int PHASE_LEN  = 130;

    typedef struct {
        logic [SMP_W-1:0] smp;
        logic             first;
        logic             last;
    } sample_item_t;

    typedef struct {
        logic signed [SMP_W-1:0] val;
        logic [6:0]              pos;
    } cand_t;

    typedef struct {
        logic [SMP_W-1:0] wmax;
        logic             fin;
    } max_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [DATA_W-1:0]    s_axis_tdata;   // sample
    logic                 s_axis_tuser;   // first
    logic                 s_axis_tlast;   // last
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [DATA_W-1:0]    m_axis_tdata;   // window_max
    logic                 m_axis_tlast;   // final_res

    sample_item_t pending_q[$];
    max_result_t  expected_max_q[$];
    cand_t        cand_q[$];
    sample_item_t next_item;

    logic [CFG_W-1:0] window_cfg;
    logic [6:0]       seq_pos;
    int               seq_filled;
    int               mismatches;
    int               idle_cycles;
    int               send_gap;
    int               stall_left;
    bit               in_taken;
    bit               calm;

    sliding_window_maximum u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic void clear_sequence();
        cand_q.delete();
        seq_pos    = '0;
        seq_filled = 0;
    endfunction

    // Advances the deque for one accepted sample and queues the window maximum
    // that it yields, if any.
    function automatic void track_window_max(input logic [SMP_W-1:0] smp_bits,
                                             input logic first_mark,
                                             input logic last_mark);
        int                      k;
        logic signed [SMP_W-1:0] smp;
        logic [6:0]              p;
        logic [6:0]              age;
        cand_t                   c;
        max_result_t             r;
        smp = smp_bits;
        k = window_cfg;
        if (k == 0)
            k = 1;
        if (k > WIN_MAX)
            k = WIN_MAX;
        if (first_mark)
            clear_sequence();
        p = seq_pos;
        // An older candidate equal to the new sample is dropped as well.
        while (cand_q.size() > 0 && cand_q[$].val <= smp)
            cand_q.delete(cand_q.size() - 1);
        while (cand_q.size() > 0)
        begin
            age = p - cand_q[0].pos;
            if (age < k)
                break;
            cand_q.delete(0);
        end
        if (cand_q.size() < WIN_MAX)
        begin
            c.val = smp;
            c.pos = p;
            cand_q = {cand_q, c};
        end
        seq_pos = p + 7'd1;
        if (seq_filled < WIN_MAX)
            seq_filled++;
        if (seq_filled >= k || last_mark)
        begin
            r.wmax = cand_q[0].val;
            r.fin  = last_mark;
            expected_max_q = {expected_max_q, r};
        end
        if (last_mark)
            clear_sequence();
    endfunction

    task automatic report_mismatch(input string what, input logic [SMP_W-1:0] got,
                                   input logic [SMP_W-1:0] want);
        $display("MISMATCH at %0t: %s, got %h, want %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Output check first, then prediction for an accepted sample.
    always @(posedge clk)
    begin
        max_result_t e;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_max_q.size() == 0)
                    report_mismatch("result with nothing expected", m_axis_tdata[SMP_W-1:0],
                                    '0);
                else
                begin
                    e = expected_max_q[0];
                    expected_max_q.delete(0);
                    if (m_axis_tdata[SMP_W-1:0] !== e.wmax)
                        report_mismatch("window_max", m_axis_tdata[SMP_W-1:0], e.wmax);
                    if (m_axis_tlast !== e.fin)
                        report_mismatch("final_res", SMP_W'(m_axis_tlast), SMP_W'(e.fin));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                track_window_max(s_axis_tdata[SMP_W-1:0], s_axis_tuser, s_axis_tlast);
                in_taken = 1'b1;
            end
            if (cfg_valid && cfg_ready)
            begin
                window_cfg = cfg_data;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIM)
        begin
            $display("Timeout: no item moved for %0d cycles", STALL_LIM);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Sample driver: holds each item until it is taken.
    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || in_taken))
        begin
            in_taken = 1'b0;
            if (send_gap > 0)
            begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                send_gap = $urandom_range(0, 12);
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_q.size() > 0)
            begin
                next_item = pending_q[0];
                pending_q.delete(0);
                s_axis_tdata  <= next_item.smp;
                s_axis_tuser  <= next_item.first;
                s_axis_tlast  <= next_item.last;
                s_axis_tvalid <= 1'b1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Result receiver with random stall bursts.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(0, 12);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    task automatic queue_sample(input logic [SMP_W-1:0] smp, input logic first_mark,
                                input logic last_mark);
        sample_item_t it;
        it.smp   = smp;
        it.first = first_mark;
        it.last  = last_mark;
        pending_q = {pending_q, it};
    endtask

    // Lets every queued sample go in and every result come out, then gives the
    // block time to finish a sample that yields nothing.
    task automatic drain_and_settle();
        while (pending_q.size() > 0 || s_axis_tvalid)
            @(posedge clk);
        while (expected_max_q.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_window(input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly whole sequences with random content; some short ones, some with
    // stray marks. A sequence cut off by the phase end stays open.
    task automatic queue_random(input int count, input int win);
        int               left;
        int               len;
        int               style;
        int               i;
        logic [SMP_W-1:0] smp;
        logic             f;
        logic             l;
        left = count;
        while (left > 0)
        begin
            style = $urandom_range(0, 9);
            if (style < 6)
                len = $urandom_range(win, 2 * win + 4);
            else if (style < 8)
                len = $urandom_range(1, win);
            else
                len = $urandom_range(1, 12);
            for (i = 0; i < len && left > 0; i++)
            begin
                case ($urandom_range(0, 5))
                    0, 1: smp = $urandom;
                    2: smp = $urandom_range(0, 6) - 3;
                    3:
                    begin
                        case ($urandom_range(0, 3))
                            0: smp = {1'b0, {(SMP_W - 1){1'b1}}};
                            1: smp = {1'b1, {(SMP_W - 1){1'b0}}};
                            2: smp = '0;
                            default: smp = '1;
                        endcase
                    end
                    4: smp = $urandom_range(0, 100);
                    default: smp = $urandom >> $urandom_range(0, 31);
                endcase
                if (style >= 8)
                begin
                    f = ($urandom_range(0, 3) == 0);
                    l = ($urandom_range(0, 3) == 0);
                end
                else
                begin
                    f = (i == 0);
                    l = (i == len - 1);
                end
                queue_sample(smp, f, l);
                left--;
            end
        end
    endtask

    initial
    begin
        int windows[10];
        int ph;
        int k;
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b1;
        window_cfg    = 7'd1;
        mismatches    = 0;
        idle_cycles   = 0;
        send_gap      = 0;
        stall_left    = 0;
        in_taken      = 1'b0;
        calm          = 1'b0;
        clear_sequence();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Window of one after reset; the very first sample has no first mark.
        queue_sample(32'h7fffffff, 1'b0, 1'b0);
        queue_sample(32'h80000000, 1'b0, 1'b0);
        queue_sample(32'h00000000, 1'b0, 1'b0);
        queue_sample(32'hffffffff, 1'b0, 1'b1);
        drain_and_settle();

        write_window(7'd3);
        // Equal values, both extremes, and a tail of equal negatives.
        queue_sample(32'd5, 1'b1, 1'b0);
        queue_sample(32'd5, 1'b0, 1'b0);
        queue_sample(32'h80000000, 1'b0, 1'b0);
        queue_sample(32'h80000000, 1'b0, 1'b0);
        queue_sample(32'h7fffffff, 1'b0, 1'b0);
        queue_sample(-32'sd3, 1'b0, 1'b0);
        queue_sample(-32'sd3, 1'b0, 1'b1);
        // A sequence shorter than the window.
        queue_sample(32'd9, 1'b1, 1'b0);
        queue_sample(-32'sd9, 1'b0, 1'b1);
        // A sequence opened without a first mark after a last one.
        queue_sample(32'd4, 1'b0, 1'b0);
        queue_sample(32'd6, 1'b0, 1'b0);
        queue_sample(32'd2, 1'b0, 1'b1);
        // Left open so the window grows mid-sequence.
        queue_sample(32'd1, 1'b1, 1'b0);
        queue_sample(32'd2, 1'b0, 1'b0);
        drain_and_settle();

        write_window(7'd5);
        queue_sample(32'd3, 1'b0, 1'b0);
        queue_sample(32'd0, 1'b0, 1'b1);
        drain_and_settle();

        write_window(7'd0);
        queue_sample(32'd10, 1'b1, 1'b0);
        queue_sample(-32'sd10, 1'b0, 1'b1);
        drain_and_settle();

        windows = '{64, 2, 127, 7, 16, 65, 1, 0, 40, 3};
        windows[8] = $urandom_range(1, 64);
        for (ph = 0; ph < 10; ph++)
        begin
            if (ph == 9)
                calm = 1'b1;
            write_window(CFG_W'(windows[ph]));
            k = windows[ph];
            if (k == 0)
                k = 1;
            if (k > WIN_MAX)
                k = WIN_MAX;
            queue_random(PHASE_LEN, k);
            drain_and_settle();
        end

        if (mismatches == 0 && expected_max_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/swm_pkg.sv
rtl/swm_cmp_unit.sv
rtl/swm_deque_ram.sv
rtl/swm_core.sv
rtl/sliding_window_maximum.sv
sim/tb_top.sv
